### src/hwo_pkg.sv
package hwo_pkg;

  localparam int CORDIC_STEPS = 24;
  localparam int CORDIC_CNT_W = $clog2(CORDIC_STEPS);

  localparam logic [15:0] DEBOUNCE_RST      = 16'd500;
  localparam logic [23:0] DIST_PER_EDGE_RST = 24'd65536;
  localparam logic [23:0] INV_BASE_RST      = 24'd1118481;
  localparam logic [15:0] SPEED_FACTOR_RST  = 16'd7373;

  localparam logic [31:0] ANG_FULL    = 32'd683565276;
  localparam logic [31:0] ANG_HALF    = 32'd341782638;
  localparam logic signed [33:0] CORDIC_INIT = 34'sd652032874;

  localparam logic signed [52:0] POSE_MAX = 53'sd140737488355327;
  localparam logic signed [52:0] POSE_MIN = -53'sd140737488355328;

  localparam logic [7:0] REG_DEBOUNCE      = 8'd0;
  localparam logic [7:0] REG_DIST_PER_EDGE = 8'd1;
  localparam logic [7:0] REG_INV_BASE      = 8'd2;
  localparam logic [7:0] REG_SPEED_FACTOR  = 8'd3;

  localparam logic [31:0] ATAN_TABLE [0:31] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
    32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
  };

  typedef enum logic [2:0] {
    S_IDLE, S_MUL, S_COLLECT, S_CORDIC, S_CWAIT, S_UPDATE, S_FINISH
  } state_t;

  typedef struct packed {
    logic               done;
    logic signed [33:0] cos_v;
    logic signed [33:0] sin_v;
  } trig_t;

endpackage

### src/hwo_mul.sv
module hwo_mul (
  input  logic        clk,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [63:0] p
);

  always_ff @(posedge clk) begin
    p <= 64'(a) * 64'(b);
  end

endmodule

### src/hwo_cordic.sv
module hwo_cordic (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [31:0]   angle,
  output hwo_pkg::trig_t trig
);

  logic signed [33:0] x, y, xs, ys;
  logic signed [32:0] z, atan;
  logic [hwo_pkg::CORDIC_CNT_W-1:0] cnt;
  logic [4:0] k;
  logic busy, flip, done;
  logic [31:0] a2;
  logic flip_next;

  assign flip_next = angle[31:30] inside {2'b01, 2'b10};
  assign a2 = flip_next ? (angle ^ 32'h8000_0000) : angle;
  assign k = 5'(cnt);
  assign xs = x >>> k;
  assign ys = y >>> k;
  assign atan = $signed({1'b0, hwo_pkg::ATAN_TABLE[k]});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == hwo_pkg::CORDIC_CNT_W'(hwo_pkg::CORDIC_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      flip <= flip_next;
      x    <= hwo_pkg::CORDIC_INIT;
      y    <= '0;
      z    <= $signed({a2[31], a2});
    end else if (busy) begin
      if (!z[32]) begin
        x <= x - ys;
        y <= y + xs;
        z <= z - atan;
      end else begin
        x <= x + ys;
        y <= y - xs;
        z <= z + atan;
      end
    end
  end

  assign trig.done  = done;
  assign trig.cos_v = flip ? -x : x;
  assign trig.sin_v = flip ? -y : y;

endmodule

### src/hall_wheel_odometry_top.sv
// Hall-sensor wheel odometry for a differential-drive robot.
// Input stream s_*: tuser bit 0 selects the request kind (0 edge, 1 poll),
// tuser bit 1 names the sensor (0 left, 1 right), tdata carries the 64-bit
// microsecond timestamp of an edge.
// An edge request is taken without leaving idle and debounced per sensor; it gives
// no result. A poll gives one result on m_*: pose, heading, wheel speeds and
// accumulated distances.
// A poll runs 16 products on one shared 32x32 multiplier (each issued in
// S_MUL and collected in S_COLLECT) and a CORDIC of 24 iterations;
// s_tready is low meanwhile. The next request may enter as soon as the
// result sits in the output register.
// If the receiver stalls, the result waits in m_tdata; edges are still
// taken, and a following poll holds in its final step until the output
// register is free.
// cfg_*: register index and data, taken in any cycle; write only when idle.
// Reset (rst, synchronous) restores register defaults and clears all
// counts, distances and the pose.
module hall_wheel_odometry_top (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [63:0]  s_tdata,   // timestamp_us
  input  logic [1:0]   s_tuser,   // operation, sensor_id
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [287:0] m_tdata,   // pos_x, pos_y, heading, speed_left,
                                  // speed_right, distance_left, distance_right
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [7:0]   cfg_index,
  input  logic [23:0]  cfg_data
);

  hwo_pkg::state_t state, state_next;
  logic [3:0]  mstep;
  logic [15:0] deb_window, speed_factor;
  logic [23:0] distance_per_edge, inverse_wheel_base;
  logic [63:0] last_edge_time [2];
  logic [31:0] edge_total [2];
  logic [31:0] previous_total [2];
  logic [47:0] wheel_distance [2];
  logic [31:0] wheel_speed [2];
  logic [47:0] d [2];
  logic signed [47:0] pose_x, pose_y;
  logic [31:0] pose_heading;
  logic [63:0] tmp;
  logic [47:0] r;
  logic [31:0] full, half;
  logic signed [51:0] inc_x, inc_y;

  logic [31:0] mul_a, mul_b;
  logic [63:0] prod;
  logic        cordic_start;
  hwo_pkg::trig_t trig;

  logic        accept, edge_ok, neg;
  logic [47:0] mag, ds;
  logic [48:0] ds_sum;
  logic [31:0] cos_abs, sin_abs, hth, dth, n0, n1;
  logic [63:0] sp_total;
  logic [79:0] trig_prod;
  logic signed [52:0] sum_x, sum_y;
  logic [48:0] wd_sum0, wd_sum1;

  assign accept    = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;
  assign edge_ok   = (s_tdata - last_edge_time[s_tuser[1]]) >= {48'd0, deb_window};

  assign n0     = edge_total[0] - previous_total[0];
  assign n1     = edge_total[1] - previous_total[1];
  assign neg    = d[0] > d[1];
  assign mag    = neg ? d[0] - d[1] : d[1] - d[0];
  assign ds_sum = {1'b0, d[0]} + {1'b0, d[1]};
  assign ds     = ds_sum[48:1];
  assign hth    = neg ? 32'd0 - half : half;
  assign dth    = neg ? 32'd0 - full : full;
  assign cos_abs = trig.cos_v[33] ? 32'(-trig.cos_v) : 32'(trig.cos_v);
  assign sin_abs = trig.sin_v[33] ? 32'(-trig.sin_v) : 32'(trig.sin_v);
  assign sp_total  = {prod[31:0], 32'd0} + tmp;
  assign trig_prod = {prod[55:0], 24'd0} + {16'd0, tmp};
  assign sum_x = 53'(pose_x) + 53'(inc_x);
  assign sum_y = 53'(pose_y) + 53'(inc_y);
  assign wd_sum0 = {1'b0, wheel_distance[0]} + {1'b0, d[0]};
  assign wd_sum1 = {1'b0, wheel_distance[1]} + {1'b0, d[1]};

  hwo_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p(prod));

  hwo_cordic u_cordic (
    .clk(clk), .rst(rst), .start(cordic_start),
    .angle(pose_heading + hth), .trig(trig)
  );

  always_comb begin
    state_next = state;
    case (state)
      hwo_pkg::S_IDLE:    if (accept && s_tuser[0]) state_next = hwo_pkg::S_MUL;
      hwo_pkg::S_MUL:     state_next = hwo_pkg::S_COLLECT;
      hwo_pkg::S_COLLECT: begin
        if (mstep == 4'd11)      state_next = hwo_pkg::S_CORDIC;
        else if (mstep == 4'd15) state_next = hwo_pkg::S_UPDATE;
        else                     state_next = hwo_pkg::S_MUL;
      end
      hwo_pkg::S_CORDIC:  state_next = hwo_pkg::S_CWAIT;
      hwo_pkg::S_CWAIT:   if (trig.done) state_next = hwo_pkg::S_MUL;
      hwo_pkg::S_UPDATE:  state_next = hwo_pkg::S_FINISH;
      hwo_pkg::S_FINISH:  if (!m_tvalid || m_tready) state_next = hwo_pkg::S_IDLE;
      default:            state_next = hwo_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    s_tready     = (state == hwo_pkg::S_IDLE);
    cordic_start = (state == hwo_pkg::S_CORDIC);
    mul_a = '0;
    mul_b = '0;
    case (mstep)
      4'd0:  begin mul_a = n0;                   mul_b = {8'd0, distance_per_edge}; end
      4'd1:  begin mul_a = n1;                   mul_b = {8'd0, distance_per_edge}; end
      4'd2:  begin mul_a = d[0][31:0];           mul_b = {16'd0, speed_factor}; end
      4'd3:  begin mul_a = {16'd0, d[0][47:32]}; mul_b = {16'd0, speed_factor}; end
      4'd4:  begin mul_a = d[1][31:0];           mul_b = {16'd0, speed_factor}; end
      4'd5:  begin mul_a = {16'd0, d[1][47:32]}; mul_b = {16'd0, speed_factor}; end
      4'd6:  begin mul_a = {8'd0, mag[23:0]};    mul_b = {8'd0, inverse_wheel_base}; end
      4'd7:  begin mul_a = {8'd0, mag[47:24]};   mul_b = {8'd0, inverse_wheel_base}; end
      4'd8:  begin mul_a = r[31:0];              mul_b = hwo_pkg::ANG_FULL; end
      4'd9:  begin mul_a = {16'd0, r[47:32]};    mul_b = hwo_pkg::ANG_FULL; end
      4'd10: begin mul_a = r[31:0];              mul_b = hwo_pkg::ANG_HALF; end
      4'd11: begin mul_a = {16'd0, r[47:32]};    mul_b = hwo_pkg::ANG_HALF; end
      4'd12: begin mul_a = {8'd0, ds[23:0]};     mul_b = cos_abs; end
      4'd13: begin mul_a = {8'd0, ds[47:24]};    mul_b = cos_abs; end
      4'd14: begin mul_a = {8'd0, ds[23:0]};     mul_b = sin_abs; end
      4'd15: begin mul_a = {8'd0, ds[47:24]};    mul_b = sin_abs; end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= hwo_pkg::S_IDLE;
      mstep              <= '0;
      m_tvalid           <= 1'b0;
      deb_window         <= hwo_pkg::DEBOUNCE_RST;
      distance_per_edge  <= hwo_pkg::DIST_PER_EDGE_RST;
      inverse_wheel_base <= hwo_pkg::INV_BASE_RST;
      speed_factor       <= hwo_pkg::SPEED_FACTOR_RST;
      for (int i = 0; i < 2; i++) begin
        last_edge_time[i] <= '0;
        edge_total[i]     <= '0;
        previous_total[i] <= '0;
        wheel_distance[i] <= '0;
        wheel_speed[i]    <= '0;
      end
      pose_x       <= '0;
      pose_y       <= '0;
      pose_heading <= '0;
    end else begin
      state <= state_next;
      if (m_tvalid && m_tready && state != hwo_pkg::S_FINISH) m_tvalid <= 1'b0;

      if (cfg_valid) begin
        case (cfg_index)
          hwo_pkg::REG_DEBOUNCE:      deb_window         <= cfg_data[15:0];
          hwo_pkg::REG_DIST_PER_EDGE: distance_per_edge  <= cfg_data;
          hwo_pkg::REG_INV_BASE:      inverse_wheel_base <= cfg_data;
          hwo_pkg::REG_SPEED_FACTOR:  speed_factor       <= cfg_data[15:0];
          default: ;
        endcase
      end

      if (accept && !s_tuser[0] && edge_ok) begin
        last_edge_time[s_tuser[1]] <= s_tdata;
        edge_total[s_tuser[1]]     <= edge_total[s_tuser[1]] + 32'd1;
      end
      if (accept && s_tuser[0]) mstep <= '0;

      if (state == hwo_pkg::S_COLLECT) begin
        if (mstep != 4'd11 && mstep != 4'd15) mstep <= mstep + 4'd1;
        case (mstep)
          4'd0: begin
            d[0] <= (prod[55:48] != 8'd0) ? '1 : prod[47:0];
            previous_total[0] <= edge_total[0];
          end
          4'd1: begin
            d[1] <= (prod[55:48] != 8'd0) ? '1 : prod[47:0];
            previous_total[1] <= edge_total[1];
          end
          4'd3:  wheel_speed[0] <= (sp_total[63:44] != '0) ? '1 : sp_total[43:12];
          4'd5:  wheel_speed[1] <= (sp_total[63:44] != '0) ? '1 : sp_total[43:12];
          4'd7:  r <= prod[47:0] + {8'd0, tmp[63:24]};
          4'd9:  full <= tmp[63:32] + prod[31:0];
          4'd11: half <= tmp[63:32] + prod[31:0];
          4'd13: inc_x <= trig.cos_v[33] ? -$signed({2'b00, trig_prod[79:30]})
                                         :  $signed({2'b00, trig_prod[79:30]});
          4'd15: inc_y <= trig.sin_v[33] ? -$signed({2'b00, trig_prod[79:30]})
                                         :  $signed({2'b00, trig_prod[79:30]});
          default: tmp <= prod;
        endcase
      end
      if (state == hwo_pkg::S_CWAIT && trig.done) mstep <= 4'd12;

      if (state == hwo_pkg::S_UPDATE) begin
        pose_x <= (sum_x > hwo_pkg::POSE_MAX) ? 48'(hwo_pkg::POSE_MAX) :
                  (sum_x < hwo_pkg::POSE_MIN) ? 48'(hwo_pkg::POSE_MIN) : sum_x[47:0];
        pose_y <= (sum_y > hwo_pkg::POSE_MAX) ? 48'(hwo_pkg::POSE_MAX) :
                  (sum_y < hwo_pkg::POSE_MIN) ? 48'(hwo_pkg::POSE_MIN) : sum_y[47:0];
        pose_heading <= pose_heading + dth;
        wheel_distance[0] <= wd_sum0[48] ? '1 : wd_sum0[47:0];
        wheel_distance[1] <= wd_sum1[48] ? '1 : wd_sum1[47:0];
      end

      if (state == hwo_pkg::S_FINISH && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == hwo_pkg::S_FINISH && (!m_tvalid || m_tready)) begin
      m_tdata <= {wheel_distance[1], wheel_distance[0], wheel_speed[1], wheel_speed[0],
                  pose_heading, pose_y, pose_x};
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    accept && s_tuser[0] |=> !s_tready)
    else $error("poll did not make the block busy");

  assert property (@(posedge clk) disable iff (rst)
    state == hwo_pkg::S_FINISH && (!m_tvalid || m_tready) |=> m_tvalid)
    else $error("result not presented after final step");

  assert property (@(posedge clk) disable iff (rst)
    accept && !s_tuser[0] |=> $stable(pose_heading) && $stable(pose_x))
    else $error("edge request moved the pose");

endmodule
